FILE: hw/rtl/ppad_pkg.sv
`timescale 1ns / 1ps
package ppad_pkg;
    localparam int COORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int LENGTH_BITS_DEF = 48;
    localparam int TARGET_BITS     = 48;
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
endpackage

FILE: hw/rtl/ppad_if.sv
`timescale 1ns / 1ps
interface ppad_in_if #(parameter int CB = 32);
    logic valid;
    logic ready;
    logic signed [CB-1:0] x_coord;
    logic signed [CB-1:0] y_coord;
    logic signed [CB-1:0] z_coord;
    logic last_point;
    modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
    modport sink (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

interface ppad_out_if #(parameter int CB = 32, parameter int LB = 48);
    logic valid;
    logic ready;
    logic signed [CB-1:0] out_x;
    logic signed [CB-1:0] out_y;
    logic signed [CB-1:0] out_z;
    logic [LB-1:0] total_length;
    logic [1:0] status;
    modport source (output valid, out_x, out_y, out_z, total_length, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, total_length, status, output ready);
endinterface

interface ppad_cfg_if;
    logic valid;
    logic ready;
    logic signed [47:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/polyline_point_at_distance_core.sv
`timescale 1ns / 1ps
// Point at a given arc length along a 3-D polyline.
// Channels: pin (points, sink), pout (one result per line, source),
// cfg (target_distance write, always ready). An item is moved when
// valid and ready are both high at a rising clk edge.
// The front stage registers each point with the sum of squares; the
// back stage latches it and takes the sum through a bit-serial square
// root (one root bit per cycle), adds the segment length with
// saturation and, on the one segment that holds the target, runs per
// coordinate a multiply in 16-bit slices and a bit-serial division. After
// the last point of a line the back stage loads the result register.
// The result register holds the line's result until pout.ready; meanwhile
// the back stage goes on with the next line and holds at that line's end,
// then the front stage fills and stalls pin.
// Reset (rst_n low, asynchronous) clears line state and target to zero.
// Write the target only while the block is idle.
module polyline_point_at_distance_core
    import ppad_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    ppad_in_if.sink pin,
    ppad_out_if.source pout,
    ppad_cfg_if.sink cfg
);
    localparam int SW = 2*COORD_BITS + 2;
    logic signed [47:0] target_reg;
    logic q_valid, q_ready, q_first, q_last;
    logic signed [COORD_BITS-1:0] qx, qy, qz, qpx, qpy, qpz;
    logic [SW-1:0] qsum;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg.valid)
            target_reg <= cfg.data;
    end

    ppad_front #(.CB(COORD_BITS), .SW(SW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pin.valid), .in_ready(pin.ready),
        .x_in(pin.x_coord), .y_in(pin.y_coord), .z_in(pin.z_coord),
        .last_in(pin.last_point),
        .q_valid(q_valid), .q_ready(q_ready),
        .qx(qx), .qy(qy), .qz(qz), .qpx(qpx), .qpy(qpy), .qpz(qpz),
        .qsum(qsum), .q_first(q_first), .q_last(q_last)
    );

    ppad_back #(.CB(COORD_BITS), .LB(LENGTH_BITS), .SW(SW)) u_back (
        .clk(clk), .rst_n(rst_n), .target(target_reg),
        .q_valid(q_valid), .q_ready(q_ready),
        .qx(qx), .qy(qy), .qz(qz), .qpx(qpx), .qpy(qpy), .qpz(qpz),
        .qsum(qsum), .q_first(q_first), .q_last(q_last),
        .o_valid(pout.valid), .o_ready(pout.ready),
        .o_x(pout.out_x), .o_y(pout.out_y), .o_z(pout.out_z),
        .o_len(pout.total_length), .o_status(pout.status)
    );
endmodule

FILE: hw/rtl/ppad_front.sv
`timescale 1ns / 1ps
// Front: computes segment deltas and sum of squares, one point per cycle when open.
module ppad_front #(
    parameter int CB = 32,
    parameter int SW = 2*CB+2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [CB-1:0] x_in,
    input  logic signed [CB-1:0] y_in,
    input  logic signed [CB-1:0] z_in,
    input  logic last_in,
    output logic q_valid,
    input  logic q_ready,
    output logic signed [CB-1:0] qx,
    output logic signed [CB-1:0] qy,
    output logic signed [CB-1:0] qz,
    output logic signed [CB-1:0] qpx,
    output logic signed [CB-1:0] qpy,
    output logic signed [CB-1:0] qpz,
    output logic [SW-1:0] qsum,
    output logic q_first,
    output logic q_last
);
    import ppad_pkg::*;
    logic signed [CB-1:0] px_reg, py_reg, pz_reg;
    logic have_reg;
    logic v_reg;
    logic signed [CB:0] dx, dy, dz;
    logic [CB:0] ax, ay, az;
    logic [SW-1:0] sum_next;

    assign in_ready = !v_reg || q_ready;
    assign q_valid = v_reg;
    assign dx = {x_in[CB-1], x_in} - {px_reg[CB-1], px_reg};
    assign dy = {y_in[CB-1], y_in} - {py_reg[CB-1], py_reg};
    assign dz = {z_in[CB-1], z_in} - {pz_reg[CB-1], pz_reg};
    assign ax = dx[CB] ? (CB+1)'(-dx) : dx;
    assign ay = dy[CB] ? (CB+1)'(-dy) : dy;
    assign az = dz[CB] ? (CB+1)'(-dz) : dz;
    assign sum_next = SW'(ax*ax) + SW'(ay*ay) + SW'(az*az);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
            have_reg <= 1'b0;
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end
        else
        begin
            if (in_ready)
                v_reg <= in_valid;
            if (in_valid && in_ready)
            begin
                px_reg <= x_in;
                py_reg <= y_in;
                pz_reg <= z_in;
                have_reg <= !last_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            qx <= x_in;
            qy <= y_in;
            qz <= z_in;
            qpx <= px_reg;
            qpy <= py_reg;
            qpz <= pz_reg;
            qsum <= sum_next;
            q_first <= !have_reg;
            q_last <= last_in;
        end
    end
endmodule

FILE: hw/rtl/ppad_back.sv
`timescale 1ns / 1ps
// Back: bit-serial sqrt, accumulate, sliced multiply and bit-serial divide per coordinate.
module ppad_back #(
    parameter int CB = 32,
    parameter int LB = 48,
    parameter int SW = 2*CB+2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic signed [47:0] target,
    input  logic q_valid,
    output logic q_ready,
    input  logic signed [CB-1:0] qx,
    input  logic signed [CB-1:0] qy,
    input  logic signed [CB-1:0] qz,
    input  logic signed [CB-1:0] qpx,
    input  logic signed [CB-1:0] qpy,
    input  logic signed [CB-1:0] qpz,
    input  logic [SW-1:0] qsum,
    input  logic q_first,
    input  logic q_last,
    output logic o_valid,
    input  logic o_ready,
    output logic signed [CB-1:0] o_x,
    output logic signed [CB-1:0] o_y,
    output logic signed [CB-1:0] o_z,
    output logic [LB-1:0] o_len,
    output logic [1:0] o_status
);
    import ppad_pkg::*;
    localparam int RB = SW/2 + 1;
    localparam int RCW = $clog2(RB+1);
    localparam int MW = CB + 1;
    localparam int NW = MW + LB;
    localparam int DCW = $clog2(NW+1);
    localparam int MCH = 16;
    localparam int NCH = (LB + MCH - 1) / MCH;
    localparam int MCW = $clog2(NCH);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQRT = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [LB-1:0] LMAX = '1;

    logic [2:0] st_reg;
    logic [RB-1:0] root_reg;
    logic [RCW-1:0] rc_reg;
    logic [LB-1:0] len_reg, span_reg, num_reg;
    logic found_reg, sat_reg;
    logic signed [CB-1:0] fx_reg, fy_reg, fz_reg;
    logic signed [CB-1:0] bx_reg, by_reg, bz_reg, bpx_reg, bpy_reg, bpz_reg;
    logic [SW-1:0] bsum_reg;
    logic [1:0] axis_reg;
    logic [MCW-1:0] mc_reg;
    logic [NW-1:0] prod_reg;
    logic [LB:0] rem_reg;
    logic [LB-1:0] quo_reg;
    logic [DCW-1:0] dc_reg;
    logic last_reg;
    logic ov_reg;

    logic [RB-1:0] cand;
    logic [2*RB-1:0] csq;
    logic [LB-1:0] ud;
    logic dneg;
    logic [LB:0] add_full;
    logic [LB-1:0] nl;
    logic signed [CB:0] diff;
    logic [MW-1:0] dmag;
    logic signed [CB-1:0] pa;
    logic [NCH*MCH-1:0] num_pad;
    logic [MCH-1:0] num_chunk;
    logic [MW+MCH-1:0] pp;
    logic [LB:0] rem_sh;
    logic inrange;
    logic signed [CB:0] res;

    assign dneg = target[47];
    assign ud = dneg ? '0 : LB'($unsigned(target));
    assign cand = root_reg | (RB'(1) << rc_reg);
    assign csq = cand * cand;
    assign add_full = {1'b0, len_reg} + {1'b0, LB'(root_reg)};
    assign nl = add_full[LB] ? LMAX : add_full[LB-1:0];
    always_comb
    begin
        unique case (axis_reg)
            2'd0: begin diff = {bx_reg[CB-1], bx_reg} - {bpx_reg[CB-1], bpx_reg}; pa = bpx_reg; end
            2'd1: begin diff = {by_reg[CB-1], by_reg} - {bpy_reg[CB-1], bpy_reg}; pa = bpy_reg; end
            default: begin diff = {bz_reg[CB-1], bz_reg} - {bpz_reg[CB-1], bpz_reg}; pa = bpz_reg; end
        endcase
    end
    assign dmag = diff[CB] ? MW'(-diff) : MW'(diff);
    // 16-bit slice of the numerator, most significant first
    assign num_pad = (NCH*MCH)'(num_reg);
    assign num_chunk = num_pad[mc_reg*MCH +: MCH];
    assign pp = dmag * num_chunk;
    assign rem_sh = {rem_reg[LB-1:0], prod_reg[NW-1]};
    assign res = diff[CB] ? {pa[CB-1], pa} - (CB+1)'(quo_reg)
                          : {pa[CB-1], pa} + (CB+1)'(quo_reg);
    assign inrange = found_reg && !dneg && ud <= len_reg;
    assign q_ready = (st_reg == S_IDLE);
    assign o_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            len_reg <= '0;
            found_reg <= 1'b0;
            sat_reg <= 1'b0;
            fx_reg <= '0; fy_reg <= '0; fz_reg <= '0;
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
            bpx_reg <= '0; bpy_reg <= '0; bpz_reg <= '0; bsum_reg <= '0;
            root_reg <= '0; rc_reg <= '0; span_reg <= '0;
            num_reg <= '0; axis_reg <= '0; mc_reg <= '0; prod_reg <= '0; rem_reg <= '0;
            quo_reg <= '0; dc_reg <= '0; last_reg <= 1'b0;
            o_x <= '0; o_y <= '0; o_z <= '0; o_len <= '0; o_status <= ST_FOUND;
        end
        else
        begin
            if (ov_reg && o_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        last_reg <= q_last;
                        if (q_first)
                        begin
                            if (!found_reg && !dneg && ud <= len_reg)
                            begin
                                found_reg <= 1'b1;
                                fx_reg <= qx; fy_reg <= qy; fz_reg <= qz;
                            end
                            st_reg <= q_last ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            bx_reg <= qx; by_reg <= qy; bz_reg <= qz;
                            bpx_reg <= qpx; bpy_reg <= qpy; bpz_reg <= qpz;
                            bsum_reg <= qsum;
                            root_reg <= '0;
                            rc_reg <= RCW'(RB-1);
                            st_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if ((2*RB)'(bsum_reg) >= csq)
                        root_reg <= cand;
                    if (rc_reg == '0)
                        st_reg <= S_ACC;
                    else
                        rc_reg <= rc_reg - 1'b1;
                end
                S_ACC:
                begin
                    if (add_full[LB] || (RB > LB && |(root_reg >> LB)))
                        sat_reg <= 1'b1;
                    len_reg <= (RB > LB && |(root_reg >> LB)) ? LMAX : nl;
                    if (!found_reg && !dneg && ud <= nl)
                    begin
                        found_reg <= 1'b1;
                        span_reg <= nl - len_reg;
                        num_reg <= (ud > len_reg) ? ud - len_reg : '0;
                        if (nl == len_reg)
                        begin
                            fx_reg <= bx_reg; fy_reg <= by_reg; fz_reg <= bz_reg;
                            st_reg <= last_reg ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            axis_reg <= 2'd0;
                            prod_reg <= '0;
                            mc_reg <= MCW'(NCH-1);
                            st_reg <= S_MUL;
                        end
                    end
                    else
                        st_reg <= last_reg ? S_OUT : S_IDLE;
                end
                S_MUL:
                begin
                    prod_reg <= (prod_reg << MCH) + NW'(pp);
                    if (mc_reg == '0)
                    begin
                        rem_reg <= '0;
                        quo_reg <= '0;
                        dc_reg <= DCW'(NW);
                        st_reg <= S_DIV;
                    end
                    else
                        mc_reg <= mc_reg - 1'b1;
                end
                S_DIV:
                begin
                    if (dc_reg == '0)
                    begin
                        unique case (axis_reg)
                            2'd0: fx_reg <= res[CB-1:0];
                            2'd1: fy_reg <= res[CB-1:0];
                            default: fz_reg <= res[CB-1:0];
                        endcase
                        if (axis_reg == 2'd2)
                            st_reg <= last_reg ? S_OUT : S_IDLE;
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                            prod_reg <= '0;
                            mc_reg <= MCW'(NCH-1);
                            st_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        prod_reg <= prod_reg << 1;
                        dc_reg <= dc_reg - 1'b1;
                        if (rem_sh >= {1'b0, span_reg})
                        begin
                            rem_reg <= rem_sh - {1'b0, span_reg};
                            quo_reg <= {quo_reg[LB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[LB-2:0], 1'b0};
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg <= 1'b1;
                        o_x <= inrange ? fx_reg : '0;
                        o_y <= inrange ? fy_reg : '0;
                        o_z <= inrange ? fz_reg : '0;
                        o_len <= len_reg;
                        o_status <= sat_reg ? ST_SAT : (inrange ? ST_FOUND : ST_RANGE);
                        len_reg <= '0;
                        found_reg <= 1'b0;
                        sat_reg <= 1'b0;
                        fx_reg <= '0; fy_reg <= '0; fz_reg <= '0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
